/* rtl/bba_pkg.sv */
// ----------------------------------------------------------------------------
// Buddy block allocator package
// Shared constants, sequencer states, free-list update and sequencer result structures.
// ----------------------------------------------------------------------------
`default_nettype none

package bba_pkg;

   // Allocator geometry
   localparam int MIN_BLOCK_BYTES = 4096;
   localparam int MIN_SHIFT       = $clog2(MIN_BLOCK_BYTES);
   localparam int MAX_ORDER       = 10;
   localparam int BLOCK_COUNT     = 1024;
   localparam int ORDER_DEPTH     = MAX_ORDER + 1;
   localparam int ORDER_W         = $clog2(ORDER_DEPTH);

   // Transaction field widths
   localparam int REQ_W    = 32;
   localparam int OFFSET_W = 10;
   localparam int ADDR_W   = 48;
   localparam int RSP_ORDER_W = 4;

   // Threshold register holds MIN_BLOCK_BYTES << order without overflow
   localparam int THRESH_W = REQ_W + 1;

   typedef logic [ORDER_W-1:0]  order_type;
   typedef logic [OFFSET_W-1:0] offset_type;

   // Sequencer states
   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_DECODE = 5'b00010,
      ST_SEARCH = 5'b00100,
      ST_SPLIT  = 5'b01000,
      ST_DONE   = 5'b10000
   } seq_state_type;

   // Free-list update from the sequencer
   typedef struct packed {
      logic       take;   // clear the free block of order idx
      logic       put;    // store a free block of order idx at offset off
      order_type  idx;
      offset_type off;
   } fl_update_type;

   // Finished transaction from the sequencer
   typedef struct packed {
      logic       done;
      logic       granted;
      offset_type offset;
      order_type  order;
   } seq_result_type;

endpackage

`default_nettype wire

/* rtl/bba_free_list.sv */
// ----------------------------------------------------------------------------
// Buddy allocator free list
// One free-block slot per order: a present bit and the block offset.
// ----------------------------------------------------------------------------
`default_nettype none

module bba_free_list (
   input  wire                    clock,
   input  wire                    reset,
   input  bba_pkg::fl_update_type update,
   input  wire bba_pkg::order_type rd_idx,
   output logic [bba_pkg::ORDER_DEPTH-1:0] present,
   output bba_pkg::offset_type    rd_offset
);
   import bba_pkg::*;

   logic [ORDER_DEPTH-1:0] present_ff;
   offset_type             offset_ff [ORDER_DEPTH];

   // Hold one slot per order; only the top order is free after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         present_ff <= ORDER_DEPTH'(1) << MAX_ORDER;
         for (int i = 0; i < ORDER_DEPTH; i++) begin
            offset_ff[i] <= '0;
         end
      end else begin
         if (update.take) begin
            present_ff[update.idx] <= 1'b0;
         end
         if (update.put) begin
            present_ff[update.idx] <= 1'b1;
            offset_ff[update.idx]  <= update.off;
         end
      end
   end

   assign present   = present_ff;
   assign rd_offset = offset_ff[rd_idx];

endmodule

`default_nettype wire

/* rtl/bba_seq.sv */
// ----------------------------------------------------------------------------
// Buddy allocator sequencer
// Walks the orders one per cycle with a shared threshold compare, then splits
// the found block down to the needed order one level per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bba_seq (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         start,
   input  wire [bba_pkg::REQ_W-1:0]    request_bytes,
   input  wire [bba_pkg::ORDER_DEPTH-1:0] present,
   input  wire bba_pkg::offset_type    rd_offset,
   output bba_pkg::order_type          rd_idx,
   output bba_pkg::fl_update_type      update,
   output bba_pkg::seq_result_type     result,
   output logic                        busy
);
   import bba_pkg::*;

   seq_state_type      state_ff, state_in;
   logic [REQ_W-1:0]   bytes_ff, bytes_in;
   logic [THRESH_W-1:0] thresh_ff, thresh_in;
   order_type          ord_ff, ord_in;
   order_type          need_ff, need_in;
   offset_type         off_ff, off_in;
   logic               granted_ff, granted_in;

   logic               fits;
   logic               at_top;
   order_type          ord_dec;

   // Shared compare: does the block of the current order hold the request
   assign fits    = {1'b0, bytes_ff} <= thresh_ff;
   assign at_top  = ord_ff == order_type'(MAX_ORDER);
   assign ord_dec = ord_ff - order_type'(1);
   assign rd_idx  = ord_ff;

   // Advance the order walk and split
   always_comb begin
      state_in   = state_ff;
      bytes_in   = bytes_ff;
      thresh_in  = thresh_ff;
      ord_in     = ord_ff;
      need_in    = need_ff;
      off_in     = off_ff;
      granted_in = granted_ff;
      update     = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               bytes_in   = request_bytes;
               thresh_in  = THRESH_W'(MIN_BLOCK_BYTES);
               ord_in     = '0;
               granted_in = 1'b0;
               state_in   = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (fits) begin
               need_in = ord_ff;
               if (present[ord_ff]) begin
                  off_in      = rd_offset;
                  update.take = 1'b1;
                  update.idx  = ord_ff;
                  granted_in  = 1'b1;
                  state_in    = ST_DONE;
               end else if (at_top) begin
                  state_in = ST_DONE;
               end else begin
                  ord_in   = ord_ff + order_type'(1);
                  state_in = ST_SEARCH;
               end
            end else if (at_top) begin
               state_in = ST_DONE;
            end else begin
               ord_in    = ord_ff + order_type'(1);
               thresh_in = thresh_ff << 1;
            end
         end
         ST_SEARCH: begin
            if (present[ord_ff]) begin
               off_in      = rd_offset;
               update.take = 1'b1;
               update.idx  = ord_ff;
               granted_in  = 1'b1;
               state_in    = ST_SPLIT;
            end else if (at_top) begin
               state_in = ST_DONE;
            end else begin
               ord_in = ord_ff + order_type'(1);
            end
         end
         ST_SPLIT: begin
            // Free the upper half one order down
            update.put = 1'b1;
            update.idx = ord_dec;
            update.off = off_ff + (offset_type'(1) << ord_dec);
            ord_in     = ord_dec;
            if (ord_dec == need_ff) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         granted_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         granted_ff <= granted_in;
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      bytes_ff  <= bytes_in;
      thresh_ff <= thresh_in;
      ord_ff    <= ord_in;
      need_ff   <= need_in;
      off_ff    <= off_in;
   end

   assign busy           = state_ff != ST_IDLE;
   assign result.done    = state_ff == ST_DONE;
   assign result.granted = granted_ff;
   assign result.offset  = off_ff;
   assign result.order   = need_ff;

endmodule

`default_nettype wire

/* rtl/buddy_block_allocator.sv */
// ----------------------------------------------------------------------------
// Buddy block allocator
// Allocation-only buddy allocator with one free slot per order.
// ----------------------------------------------------------------------------
//  Channel   | Ports                                   | Handshake
//  ----------+-----------------------------------------+-------------------
//  request   | req_request_bytes                       | start, busy
//  response  | rsp_granted/block_offset/address/order  | rsp_strobe
//  config    | csr_wdata                               | csr_we
//
//  A transaction walks the orders one per cycle during the size decode and
//  free-slot search, splits the block one order per cycle, finishes in ST_DONE
//  and then registers the response that rsp_strobe marks.
//  Reset is synchronous and leaves one free block of the top order at
//  offset 0 and base_address 0. The receiver cannot stall; each response is
//  valid for the single cycle that rsp_strobe is high.
// ----------------------------------------------------------------------------
`default_nettype none

module buddy_block_allocator (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         start,
   output logic                        busy,
   input  wire [bba_pkg::REQ_W-1:0]    req_request_bytes,
   output logic                        rsp_strobe,
   output logic                        rsp_granted,
   output logic [bba_pkg::OFFSET_W-1:0] rsp_block_offset,
   output logic [bba_pkg::ADDR_W-1:0]  rsp_block_address,
   output logic [bba_pkg::RSP_ORDER_W-1:0] rsp_block_order,
   input  wire                         csr_we,
   input  wire [bba_pkg::ADDR_W-1:0]   csr_wdata
);
   import bba_pkg::*;

   logic [ADDR_W-1:0]      base_ff;
   logic [ORDER_DEPTH-1:0] present;
   offset_type             rd_offset;
   order_type              rd_idx;
   fl_update_type          update;
   seq_result_type         result;

   logic                   strobe_ff;
   logic                   granted_ff;
   offset_type             offset_ff;
   logic [ADDR_W-1:0]      address_ff;
   logic [RSP_ORDER_W-1:0] order_ff;

   bba_free_list u_free_list (
      .clock     (clock),
      .reset     (reset),
      .update    (update),
      .rd_idx    (rd_idx),
      .present   (present),
      .rd_offset (rd_offset)
   );

   bba_seq u_seq (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .request_bytes (req_request_bytes),
      .present       (present),
      .rd_offset     (rd_offset),
      .rd_idx        (rd_idx),
      .update        (update),
      .result        (result),
      .busy          (busy)
   );

   // Base address register
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= '0;
      end else if (csr_we) begin
         base_ff <= csr_wdata;
      end
   end

   // Response strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= result.done;
      end
   end

   // Response payload; zero the fields of a failed transaction
   always_ff @(posedge clock) begin
      if (result.done) begin
         granted_ff <= result.granted;
         if (result.granted) begin
            offset_ff  <= result.offset;
            address_ff <= base_ff + (ADDR_W'(result.offset) << MIN_SHIFT);
            order_ff   <= RSP_ORDER_W'(result.order);
         end else begin
            offset_ff  <= '0;
            address_ff <= '0;
            order_ff   <= '0;
         end
      end
   end

   assign rsp_strobe        = strobe_ff;
   assign rsp_granted       = granted_ff;
   assign rsp_block_offset  = offset_ff;
   assign rsp_block_address = address_ff;
   assign rsp_block_order   = order_ff;

   // An accepted transaction keeps the block busy
   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("busy not raised after start");

   // A response only follows a transaction in flight
   a_strobe_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("response without transaction");

   // A failed response carries zero fields
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_granted |->
         rsp_block_offset == '0 && rsp_block_address == '0 && rsp_block_order == '0)
      else $error("failed response has nonzero fields");

   // A granted block is aligned to its own size
   a_aligned: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_granted |->
         (rsp_block_offset & ((OFFSET_W'(1) << rsp_block_order) - OFFSET_W'(1))) == '0)
      else $error("granted block misaligned");

endmodule

`default_nettype wire
